// File: rtl/core/assert_macros.svh
// Shared assertion macros for the scancode stack checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while out of reset.
`define S2A_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("s2a_stk: assertion failed");

// Property checked on every edge, reset included.
`define S2A_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("s2a_stk: assertion failed");

`endif

// File: rtl/core/s2a_stk_pkg.sv
package s2a_stk_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] SC_SHIFT       = 8'h2A;
    localparam logic [7:0] SC_SHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_CAPS        = 8'h3A;
    localparam logic [7:0] SC_ALT         = 8'h38;
    localparam logic [7:0] SC_KEY_R       = 8'h13;
    localparam logic [7:0] SC_KEY_T       = 8'h14;
    localparam logic [7:0] TABLE_LEN      = 8'd59;

    typedef enum logic {
        OP_EVENT = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } t_state;

    typedef struct packed {
        logic evt;         // scancode event accepted
        logic rd_empty;    // read accepted on an empty stack
        logic pop_start;   // read accepted, memory read issued
        logic pop_finish;  // popped byte available
    } t_cmd;

    typedef struct packed {
        logic q_room;
        logic stack_empty;
    } t_stat;

    typedef struct packed {
        logic [7:0] read_data;
        logic       was_empty;
        logic       snapshot_request;
        logic       context_switch;
        logic       dropped;
    } t_result;

    // Set-1 key map: left column shifted, right column plain.
    function automatic logic [7:0] key_char(input logic [5:0] idx, input logic shifted);
        logic [7:0] ch;
        ch = 8'h00;
        case (idx)
            6'd2:  ch = shifted ? "!"   : "1";
            6'd3:  ch = shifted ? "@"   : "2";
            6'd4:  ch = shifted ? "#"   : "3";
            6'd5:  ch = shifted ? "$"   : "4";
            6'd6:  ch = shifted ? "%"   : "5";
            6'd7:  ch = shifted ? "^"   : "6";
            6'd8:  ch = shifted ? "/"   : "7";
            6'd9:  ch = shifted ? "("   : "8";
            6'd10: ch = shifted ? ")"   : "9";
            6'd11: ch = shifted ? "="   : "0";
            6'd12: ch = shifted ? "_"   : "&";
            6'd13: ch = shifted ? "+"   : "-";
            6'd14: ch = 8'h08;
            6'd15: ch = 8'h09;
            6'd16: ch = shifted ? "Q"   : "q";
            6'd17: ch = shifted ? "W"   : "w";
            6'd18: ch = shifted ? "E"   : "e";
            6'd19: ch = shifted ? "R"   : "r";
            6'd20: ch = shifted ? "T"   : "t";
            6'd21: ch = shifted ? "Y"   : "y";
            6'd22: ch = shifted ? "U"   : "u";
            6'd23: ch = shifted ? "I"   : "i";
            6'd24: ch = shifted ? "O"   : "o";
            6'd25: ch = shifted ? "P"   : "p";
            6'd26: ch = shifted ? "{"   : "[";
            6'd27: ch = shifted ? "*"   : "+";
            6'd28: ch = 8'h0A;
            6'd30: ch = shifted ? "A"   : "a";
            6'd31: ch = shifted ? "S"   : "s";
            6'd32: ch = shifted ? "D"   : "d";
            6'd33: ch = shifted ? "F"   : "f";
            6'd34: ch = shifted ? "G"   : "g";
            6'd35: ch = shifted ? "H"   : "h";
            6'd36: ch = shifted ? "J"   : "j";
            6'd37: ch = shifted ? "K"   : "k";
            6'd38: ch = shifted ? "L"   : "l";
            6'd39: ch = shifted ? ":"   : ";";
            6'd40: ch = shifted ? 8'h22 : 8'h27;
            6'd41: ch = shifted ? "~"   : 8'hB0;  // degree sign
            6'd43: ch = shifted ? "|"   : 8'h5C;
            6'd44: ch = shifted ? "Z"   : "z";
            6'd45: ch = shifted ? "X"   : "x";
            6'd46: ch = shifted ? "C"   : "c";
            6'd47: ch = shifted ? "V"   : "v";
            6'd48: ch = shifted ? "B"   : "b";
            6'd49: ch = shifted ? "N"   : "n";
            6'd50: ch = shifted ? "M"   : "m";
            6'd51: ch = shifted ? "<"   : ",";
            6'd52: ch = shifted ? ">"   : ".";
            6'd53: ch = shifted ? "?"   : "-";
            6'd57: ch = " ";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/core/s2a_stk_if.sv
interface s2a_stk_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] scancode;
    logic       current_context;

    modport source (output valid, operation, scancode, current_context, input ready);
    modport sink   (input valid, operation, scancode, current_context, output ready);
endinterface

interface s2a_stk_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       was_empty;
    logic       snapshot_request;
    logic       context_switch;
    logic       dropped;

    modport source (output valid, read_data, was_empty, snapshot_request, context_switch,
                    dropped, input ready);
    modport sink   (input valid, read_data, was_empty, snapshot_request, context_switch,
                    dropped, output ready);
endinterface

// File: rtl/core/scancode_to_ascii_stack.sv
// An event's result is queued as its beat is taken; a read's popped byte is queued
// from ST_POP, after the registered stack memory read.
// Throughput: one event per cycle if the queue has room; reads hold input in ST_POP.
// A two-entry result queue lets input beats be taken while a result waits.
// Reset (synchronous, active low): shift and alt cleared, caps off, stack emptied,
// active side 0, result queue flushed; stack memory contents are left as they are.
module scancode_to_ascii_stack (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    s2a_stk_in_if.sink           i_in,
    s2a_stk_out_if.source        o_out
);

    s2a_stk_pkg::t_cmd    cmd;
    s2a_stk_pkg::t_stat   stat;
    s2a_stk_pkg::t_result result;
    logic                 in_ready;
    logic                 out_valid;

    s2a_stk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.operation),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    s2a_stk_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_scancode        (i_in.scancode),
        .i_current_context (i_in.current_context),
        .i_cmd             (cmd),
        .i_out_ready       (o_out.ready),
        .o_stat            (stat),
        .o_out_valid       (out_valid),
        .o_result          (result)
    );

    assign i_in.ready             = in_ready;
    assign o_out.valid            = out_valid;
    assign o_out.read_data        = result.read_data;
    assign o_out.was_empty        = result.was_empty;
    assign o_out.snapshot_request = result.snapshot_request;
    assign o_out.context_switch   = result.context_switch;
    assign o_out.dropped          = result.dropped;

endmodule

// File: rtl/core/s2a_stk_ctrl.sv
module s2a_stk_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_op,
    input  s2a_stk_pkg::t_stat i_stat,
    output logic               o_in_ready,
    output s2a_stk_pkg::t_cmd  o_cmd
);

    s2a_stk_pkg::t_state r_state;
    s2a_stk_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= s2a_stk_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            s2a_stk_pkg::ST_IDLE: begin
                o_in_ready = i_stat.q_room;
                if (i_in_valid && i_stat.q_room) begin
                    if (i_in_op == s2a_stk_pkg::OP_READ) begin
                        if (i_stat.stack_empty) begin
                            o_cmd.rd_empty = 1'b1;
                        end else begin
                            o_cmd.pop_start = 1'b1;
                            n_state         = s2a_stk_pkg::ST_POP;
                        end
                    end else begin
                        o_cmd.evt = 1'b1;
                    end
                end
            end
            s2a_stk_pkg::ST_POP: begin
                // memory data is registered: queue the popped byte now
                o_cmd.pop_finish = 1'b1;
                n_state          = s2a_stk_pkg::ST_IDLE;
            end
            default: begin
                n_state = s2a_stk_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/s2a_stk_dp.sv
module s2a_stk_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic [7:0]           i_scancode,
    input  logic                 i_current_context,
    input  s2a_stk_pkg::t_cmd    i_cmd,
    input  logic                 i_out_ready,
    output s2a_stk_pkg::t_stat   o_stat,
    output logic                 o_out_valid,
    output s2a_stk_pkg::t_result o_result
);

    localparam int ADDR_W = s2a_stk_pkg::ADDR_W;
    localparam int CNT_W  = s2a_stk_pkg::CNT_W;

    logic                 r_active_side;
    logic                 r_shift;
    logic                 n_shift;
    logic                 r_caps_off;
    logic                 n_caps_off;
    logic                 r_alt;
    logic                 n_alt;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [7:0]           r_mem [s2a_stk_pkg::STACK_DEPTH];
    logic [7:0]           r_rd_data;
    s2a_stk_pkg::t_result r_q [2];
    logic                 r_q_wr;
    logic                 r_q_rd;
    logic [1:0]           r_q_cnt;
    logic [1:0]           n_q_cnt;

    logic                 in_table;
    logic                 alt_tog;
    logic [7:0]           ch;
    logic                 full;
    logic                 do_push;
    logic [ADDR_W-1:0]    pop_addr;
    logic                 enq;
    logic                 deq;
    s2a_stk_pkg::t_result enq_data;

    assign in_table = i_scancode < s2a_stk_pkg::TABLE_LEN;
    assign full     = r_count == CNT_W'(s2a_stk_pkg::STACK_DEPTH);
    assign pop_addr = ADDR_W'(r_count - CNT_W'(1));

    // Event decode: shift and caps take effect before the lookup, alt after.
    always_comb begin
        n_shift    = r_shift;
        n_caps_off = r_caps_off;
        n_alt      = r_alt;
        alt_tog    = r_alt;
        do_push    = 1'b0;
        enq_data   = '0;
        ch         = 8'h00;
        if (in_table) begin
            if (i_scancode == s2a_stk_pkg::SC_SHIFT) begin
                n_shift = 1'b1;
            end
            if (i_scancode == s2a_stk_pkg::SC_CAPS) begin
                n_caps_off = ~r_caps_off;
            end
            ch      = s2a_stk_pkg::key_char(i_scancode[5:0], n_caps_off == n_shift);
            alt_tog = r_alt ^ (i_scancode == s2a_stk_pkg::SC_ALT);
            n_alt   = alt_tog;
            if (i_scancode == s2a_stk_pkg::SC_KEY_R && alt_tog) begin
                enq_data.snapshot_request = 1'b1;
                n_alt = 1'b0;
            end else if (i_scancode == s2a_stk_pkg::SC_KEY_T && alt_tog
                         && i_current_context == r_active_side) begin
                enq_data.context_switch = 1'b1;
                n_alt = 1'b0;
            end else if (ch != 8'h00) begin
                if (full) begin
                    enq_data.dropped = 1'b1;
                end else begin
                    do_push = 1'b1;
                end
            end
        end else if (i_scancode == s2a_stk_pkg::SC_SHIFT_BREAK) begin
            n_shift = 1'b0;
        end

        if (i_cmd.rd_empty) begin
            enq_data           = '0;
            enq_data.was_empty = 1'b1;
        end else if (i_cmd.pop_finish) begin
            enq_data           = '0;
            enq_data.read_data = r_rd_data;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.evt && do_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop_start) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_side <= 1'b0;
            r_shift       <= 1'b0;
            r_caps_off    <= 1'b1;
            r_alt         <= 1'b0;
            r_count       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_active_side <= i_cfg_wdata;
            end
            if (i_cmd.evt) begin
                r_shift    <= n_shift;
                r_caps_off <= n_caps_off;
                r_alt      <= n_alt;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.evt && do_push) begin
            r_mem[r_count[ADDR_W-1:0]] <= ch;
        end
        if (i_cmd.pop_start) begin
            r_rd_data <= r_mem[pop_addr];
        end
    end

    // Two-entry result queue: the input side keeps going while a beat waits.
    assign enq = i_cmd.evt || i_cmd.rd_empty || i_cmd.pop_finish;
    assign deq = o_out_valid && i_out_ready;

    always_comb begin
        n_q_cnt = r_q_cnt;
        case ({enq, deq})
            2'b10:   n_q_cnt = r_q_cnt + 2'd1;
            2'b01:   n_q_cnt = r_q_cnt - 2'd1;
            default: n_q_cnt = r_q_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr  <= 1'b0;
            r_q_rd  <= 1'b0;
            r_q_cnt <= '0;
        end else begin
            if (enq) begin
                r_q_wr <= ~r_q_wr;
            end
            if (deq) begin
                r_q_rd <= ~r_q_rd;
            end
            r_q_cnt <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_q_wr] <= enq_data;
        end
    end

    assign o_out_valid        = r_q_cnt != 2'd0;
    assign o_result           = r_q[r_q_rd];
    assign o_stat.q_room      = r_q_cnt != 2'd2;
    assign o_stat.stack_empty = r_count == '0;

endmodule

// File: rtl/core/s2a_stk_chk.sv
`include "assert_macros.svh"

module s2a_stk_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_read_data,
    input logic       i_was_empty,
    input logic       i_snapshot_request,
    input logic       i_context_switch,
    input logic       i_dropped
);

    // a stalled beat stays offered
    `S2A_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)

    // at most one flag per result
    `S2A_ASSERT(a_one_flag, i_clk, i_rst_n, i_out_valid |-> $onehot0({i_was_empty, i_snapshot_request, i_context_switch, i_dropped}))

    // any flagged result carries no character
    `S2A_ASSERT(a_flag_no_data, i_clk, i_rst_n, i_out_valid && (i_was_empty || i_snapshot_request || i_context_switch || i_dropped) |-> i_read_data == 8'h00)

    // nothing offered straight after reset
    `S2A_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind scancode_to_ascii_stack s2a_stk_chk u_s2a_stk_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_read_data        (o_out.read_data),
    .i_was_empty        (o_out.was_empty),
    .i_snapshot_request (o_out.snapshot_request),
    .i_context_switch   (o_out.context_switch),
    .i_dropped          (o_out.dropped)
);

// File: tb/tb_scancode_to_ascii_stack.sv
`timescale 1ns / 1ps

module tb_scancode_to_ascii_stack;
    import s2a_stk_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 27;

    typedef enum logic {
        ROW_KEY,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic    fixed;
        t_result want;
    } t_answer;

    typedef struct packed {
        t_row_kind  kind;
        t_op        op;
        logic [7:0] code;
        logic       ctx;
        logic       fixed;
        t_result    want;
    } t_row;

    localparam t_result NO_OUTPUT  = '0;
    localparam t_result EMPTY_READ = '{read_data: 8'h00, was_empty: 1'b1,
                                       snapshot_request: 1'b0, context_switch: 1'b0,
                                       dropped: 1'b0};
    localparam t_result SNAPSHOT   = '{read_data: 8'h00, was_empty: 1'b0,
                                       snapshot_request: 1'b1, context_switch: 1'b0,
                                       dropped: 1'b0};
    localparam t_result SWITCH     = '{read_data: 8'h00, was_empty: 1'b0,
                                       snapshot_request: 1'b0, context_switch: 1'b1,
                                       dropped: 1'b0};

    // Set-1 key columns, indexed by scancode
    localparam logic [7:0] KEY_PLAIN [59] = '{
        8'h00, 8'h00, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0",
        "&", "-", 8'h08, 8'h09, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p",
        "[", "+", 8'h0A, 8'h00, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";",
        8'h27, 8'hB0, 8'h00, 8'h5C, "z", "x", "c", "v", "b", "n", "m", ",", ".", "-",
        8'h00, 8'h00, 8'h00, " ", 8'h00
    };
    localparam logic [7:0] KEY_SHIFT [59] = '{
        8'h00, 8'h00, "!", "@", "#", "$", "%", "^", "/", "(", ")", "=",
        "_", "+", 8'h08, 8'h09, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P",
        "{", "*", 8'h0A, 8'h00, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":",
        8'h22, "~", 8'h00, "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?",
        8'h00, 8'h00, 8'h00, " ", 8'h00
    };

    localparam int N_ROWS = 25;
    localparam t_row DIRECTED [N_ROWS] = '{
        '{ROW_KEY, OP_READ,  8'hFF,          1'b1, 1'b1, EMPTY_READ},
        '{ROW_KEY, OP_EVENT, 8'h00,          1'b0, 1'b1, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, 8'hFF,          1'b1, 1'b1, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, 8'h10,          1'b0, 1'b0, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, SC_SHIFT,       1'b0, 1'b1, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, 8'h29,          1'b0, 1'b0, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, SC_SHIFT_BREAK, 1'b0, 1'b1, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, 8'h29,          1'b0, 1'b0, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, SC_CAPS,        1'b0, 1'b1, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, 8'h1E,          1'b0, 1'b0, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, SC_CAPS,        1'b0, 1'b1, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, 8'h3B,          1'b0, 1'b1, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, SC_ALT,         1'b0, 1'b1, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, SC_KEY_R,       1'b0, 1'b1, SNAPSHOT},
        '{ROW_KEY, OP_EVENT, SC_KEY_R,       1'b0, 1'b0, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, SC_ALT,         1'b0, 1'b1, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, SC_KEY_T,       1'b1, 1'b0, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, SC_KEY_T,       1'b0, 1'b1, SWITCH},
        '{ROW_CFG, OP_EVENT, 8'h00,          1'b1, 1'b0, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, SC_ALT,         1'b0, 1'b1, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, SC_KEY_T,       1'b1, 1'b1, SWITCH},
        '{ROW_KEY, OP_EVENT, 8'h39,          1'b0, 1'b0, NO_OUTPUT},
        '{ROW_KEY, OP_READ,  8'h00,          1'b0, 1'b0, NO_OUTPUT},
        '{ROW_KEY, OP_READ,  8'h5A,          1'b1, 1'b0, NO_OUTPUT},
        '{ROW_KEY, OP_EVENT, 8'h0E,          1'b0, 1'b0, NO_OUTPUT}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    s2a_stk_in_if  in_if ();
    s2a_stk_out_if out_if ();

    scancode_to_ascii_stack dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow keyboard state
    logic        shift_down  = 1'b0;
    logic        caps_clear  = 1'b1;
    logic        alt_armed   = 1'b0;
    logic        side_cfg    = 1'b0;
    logic [7:0]  typed_chars [STACK_DEPTH];
    int unsigned chars_held  = 0;

    t_result owed_results [$];
    t_answer typed_answers [$];
    int      mismatches   = 0;
    int      quiet_cycles = 0;
    bit      calm         = 1'b0;
    bit      hold_req     = 1'b0;

    function automatic t_result predict_keystroke(input t_op op, input logic [7:0] code,
                                                  input logic ctx);
        t_result    res;
        logic [7:0] ch;
        res = '0;
        if (op == OP_READ) begin
            if (chars_held == 0) begin
                res.was_empty = 1'b1;
            end else begin
                chars_held--;
                res.read_data = typed_chars[chars_held];
            end
        end else if (code < TABLE_LEN) begin
            if (code == SC_SHIFT)
                shift_down = 1'b1;
            if (code == SC_CAPS)
                caps_clear = ~caps_clear;
            ch = (caps_clear == shift_down) ? KEY_SHIFT[code] : KEY_PLAIN[code];
            if (code == SC_ALT)
                alt_armed = ~alt_armed;
            if (code == SC_KEY_R && alt_armed) begin
                res.snapshot_request = 1'b1;
                alt_armed = 1'b0;
            end else if (code == SC_KEY_T && alt_armed && ctx == side_cfg) begin
                res.context_switch = 1'b1;
                alt_armed = 1'b0;
            end else if (ch != 8'h00) begin
                if (chars_held < STACK_DEPTH) begin
                    typed_chars[chars_held] = ch;
                    chars_held++;
                end else begin
                    res.dropped = 1'b1;
                end
            end
        end else if (code == SC_SHIFT_BREAK) begin
            shift_down = 1'b0;
        end
        return res;
    endfunction

    task automatic report_result(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected data=%02h empty=%b snap=%b switch=%b drop=%b,",
                     $time, what, want.read_data, want.was_empty, want.snapshot_request,
                     want.context_switch, want.dropped,
                     " got data=%02h empty=%b snap=%b switch=%b drop=%b",
                     got.read_data, got.was_empty, got.snapshot_request,
                     got.context_switch, got.dropped);
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_result got;
        t_result want;
        t_result fresh;
        t_answer tag;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got.read_data        = out_if.read_data;
                got.was_empty        = out_if.was_empty;
                got.snapshot_request = out_if.snapshot_request;
                got.context_switch   = out_if.context_switch;
                got.dropped          = out_if.dropped;
                if (owed_results.size() == 0) begin
                    report_result("result with nothing owed", NO_OUTPUT, got);
                end else begin
                    want = owed_results.pop_front();
                    if (got.read_data !== want.read_data || got.was_empty !== want.was_empty
                            || got.snapshot_request !== want.snapshot_request
                            || got.context_switch !== want.context_switch
                            || got.dropped !== want.dropped)
                        report_result("mismatch", want, got);
                end
            end
            if (i_cfg_we)
                side_cfg = i_cfg_wdata;
            if (in_if.valid && in_if.ready) begin
                tag   = typed_answers.pop_front();
                fresh = predict_keystroke(t_op'(in_if.operation), in_if.scancode,
                                          in_if.current_context);
                owed_results.push_back(tag.fixed ? tag.want : fresh);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random back-pressure, long hold on request
    initial begin : drain
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_item(input t_op op, input logic [7:0] code, input logic ctx,
                             input logic fixed, input t_result want);
        t_answer tag;
        tag.fixed = fixed;
        tag.want  = want;
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        typed_answers.push_back(tag);
        in_if.valid           <= 1'b1;
        in_if.operation       <= op;
        in_if.scancode        <= code;
        in_if.current_context <= ctx;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
    endtask

    task automatic write_side(input logic side);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (owed_results.size() != 0)
            @(posedge i_clk);
        // let a read still in the memory port finish
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= side;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] any_key();
        logic [7:0] code;
        do
            code = 8'($urandom_range(2, 57));
        while (KEY_PLAIN[code] == 8'h00);
        return code;
    endfunction

    task automatic send_random(input int read_pct, input int key_pct);
        int pick;
        pick = $urandom_range(99);
        if (pick < read_pct) begin
            send_item(OP_READ, 8'($urandom), 1'($urandom), 1'b0, NO_OUTPUT);
        end else if ($urandom_range(99) < key_pct) begin
            send_item(OP_EVENT, any_key(), 1'($urandom), 1'b0, NO_OUTPUT);
        end else begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                // alt chord: alt then R or T
                send_item(OP_EVENT, SC_ALT, 1'($urandom), 1'b0, NO_OUTPUT);
                send_item(OP_EVENT, $urandom_range(1) ? SC_KEY_T : SC_KEY_R,
                          1'($urandom), 1'b0, NO_OUTPUT);
            end else if (pick < 45) begin
                send_item(OP_EVENT, SC_SHIFT, 1'($urandom), 1'b0, NO_OUTPUT);
            end else if (pick < 60) begin
                send_item(OP_EVENT, SC_SHIFT_BREAK, 1'($urandom), 1'b0, NO_OUTPUT);
            end else if (pick < 72) begin
                send_item(OP_EVENT, SC_CAPS, 1'($urandom), 1'b0, NO_OUTPUT);
            end else if (pick < 80) begin
                send_item(OP_EVENT, SC_ALT, 1'($urandom), 1'b0, NO_OUTPUT);
            end else begin
                send_item(OP_EVENT, 8'($urandom_range(255)), 1'($urandom), 1'b0, NO_OUTPUT);
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_wdata           = 1'b0;
        in_if.valid           = 1'b0;
        in_if.operation       = 1'b0;
        in_if.scancode        = 8'h00;
        in_if.current_context = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_CFG)
                write_side(DIRECTED[i].ctx);
            else
                send_item(DIRECTED[i].op, DIRECTED[i].code, DIRECTED[i].ctx,
                          DIRECTED[i].fixed, DIRECTED[i].want);
        end

        write_side(1'b1);
        repeat (150) send_random(25, 60);

        // fill the stack past full while the result side holds off at first
        write_side(1'b0);
        hold_req = 1'b1;
        repeat (1150) send_random(0, 92);

        write_side(1'b1);
        calm = 1'b1;
        repeat (150) send_random(60, 60);
        calm = 1'b0;
        repeat (100) send_random(60, 60);

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (owed_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
